[sv/evr_pkg.sv]
// ----------------------------------------------------------------------------
// evr_pkg: shared types and constants for the ellipse vertex generator
// Fixed-point widths, register indexes, configuration and result records,
// and the saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package evr_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS    = 14;
  localparam int COORD_WIDTH  = 16;
  localparam int UNIT_WIDTH   = FRAC_BITS + 2;
  localparam int STEP_FRAC    = 14;
  localparam int STEP_WIDTH   = 16;
  localparam int RADIUS_WIDTH = 15;
  localparam int CENTER_WIDTH = 16;
  localparam int INDEX_WIDTH  = 16;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  // Vertex scaling: signed unit times zero-extended radius
  localparam int SCALE_WIDTH  = UNIT_WIDTH + RADIUS_WIDTH + 1;
  localparam int SCALED_WIDTH = SCALE_WIDTH - FRAC_BITS;
  localparam int VSUM_BASE    = (SCALED_WIDTH > CENTER_WIDTH) ? SCALED_WIDTH : CENTER_WIDTH;
  localparam int VSUM_WIDTH   = ((VSUM_BASE > COORD_WIDTH) ? VSUM_BASE : COORD_WIDTH) + 1;

  // Rotation: step coefficient times unit component, two products summed
  localparam int ROT_PROD_WIDTH  = UNIT_WIDTH + STEP_WIDTH;
  localparam int ROT_SUM_WIDTH   = ROT_PROD_WIDTH + 1;
  localparam int ROT_SHIFT_WIDTH = ROT_SUM_WIDTH - STEP_FRAC;

  // Rounding offsets (half an LSB of the result)
  localparam logic signed [SCALE_WIDTH-1:0]   SCALE_HALF =
    SCALE_WIDTH'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [ROT_SUM_WIDTH-1:0] ROT_HALF   =
    ROT_SUM_WIDTH'(64'sd1 <<< (STEP_FRAC - 1));

  // Saturation bounds
  localparam logic signed [VSUM_WIDTH-1:0] COORD_MAX =
    VSUM_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [VSUM_WIDTH-1:0] COORD_MIN =
    VSUM_WIDTH'(-(64'sd1 <<< (COORD_WIDTH - 1)));
  localparam logic signed [ROT_SHIFT_WIDTH-1:0] UNIT_MAX =
    ROT_SHIFT_WIDTH'((64'sd1 <<< (UNIT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ROT_SHIFT_WIDTH-1:0] UNIT_MIN =
    ROT_SHIFT_WIDTH'(-(64'sd1 <<< (UNIT_WIDTH - 1)));

  // Angle zero: unit vector (1.0, 0)
  localparam logic signed [UNIT_WIDTH-1:0] UNIT_ONE = UNIT_WIDTH'(64'sd1 <<< FRAC_BITS);

  // Register reset values
  localparam logic signed [STEP_WIDTH-1:0] STEP_COS_RESET = STEP_WIDTH'(16384);
  localparam logic [INDEX_WIDTH-1:0]       SEG_RESET      = INDEX_WIDTH'(64);

  // Register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_RADIUS_X      = 3'd2,
    REG_RADIUS_Y      = 3'd3,
    REG_STEP_COSINE   = 3'd4,
    REG_STEP_SINE     = 3'd5,
    REG_SEGMENT_COUNT = 3'd6
  } cfg_reg_t;

  // Configuration register file
  typedef struct packed {
    logic signed [CENTER_WIDTH-1:0] center_x;
    logic signed [CENTER_WIDTH-1:0] center_y;
    logic [RADIUS_WIDTH-1:0]        radius_x;
    logic [RADIUS_WIDTH-1:0]        radius_y;
    logic signed [STEP_WIDTH-1:0]   step_cosine;
    logic signed [STEP_WIDTH-1:0]   step_sine;
    logic [INDEX_WIDTH-1:0]         segment_count;
  } cfg_t;

  // One emitted vertex
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          last_of_loop;
  } vertex_t;

  // Clamp a widened coordinate sum into the coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [VSUM_WIDTH-1:0] v
  );
    logic signed [VSUM_WIDTH-1:0] r;
    r = v;
    if (v > COORD_MAX) r = COORD_MAX;
    if (v < COORD_MIN) r = COORD_MIN;
    return r[COORD_WIDTH-1:0];
  endfunction

  // Clamp a rotated component into the unit vector range
  function automatic logic signed [UNIT_WIDTH-1:0] sat_unit(
    input logic signed [ROT_SHIFT_WIDTH-1:0] v
  );
    logic signed [ROT_SHIFT_WIDTH-1:0] r;
    r = v;
    if (v > UNIT_MAX) r = UNIT_MAX;
    if (v < UNIT_MIN) r = UNIT_MIN;
    return r[UNIT_WIDTH-1:0];
  endfunction

endpackage

[sv/evr_core.sv]
// ----------------------------------------------------------------------------
// evr_core: vertex datapath and rotation state
// Scales the current unit vector into a vertex and on every accepted request
// rotates it by the step angle, or after the last vertex returns to angle zero.
// ----------------------------------------------------------------------------
module evr_core
  import evr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    restart,
  input  cfg_t    cfg,
  output vertex_t vertex
);

  logic signed [UNIT_WIDTH-1:0]      unit_x;
  logic signed [UNIT_WIDTH-1:0]      unit_y;
  logic [INDEX_WIDTH-1:0]            vertex_index;
  logic signed [UNIT_WIDTH-1:0]      unit_x_next;
  logic signed [UNIT_WIDTH-1:0]      unit_y_next;
  logic [INDEX_WIDTH-1:0]            vertex_index_next;

  logic signed [UNIT_WIDTH-1:0]      cur_x;
  logic signed [UNIT_WIDTH-1:0]      cur_y;
  logic [INDEX_WIDTH-1:0]            cur_idx;

  logic signed [SCALE_WIDTH-1:0]     prod_x;
  logic signed [SCALE_WIDTH-1:0]     prod_y;
  logic signed [SCALE_WIDTH-1:0]     rnd_x;
  logic signed [SCALE_WIDTH-1:0]     rnd_y;
  logic signed [SCALED_WIDTH-1:0]    scaled_x;
  logic signed [SCALED_WIDTH-1:0]    scaled_y;
  logic signed [VSUM_WIDTH-1:0]      vsum_x;
  logic signed [VSUM_WIDTH-1:0]      vsum_y;

  logic signed [ROT_PROD_WIDTH-1:0]  p_cx;
  logic signed [ROT_PROD_WIDTH-1:0]  p_sy;
  logic signed [ROT_PROD_WIDTH-1:0]  p_sx;
  logic signed [ROT_PROD_WIDTH-1:0]  p_cy;
  logic signed [ROT_SUM_WIDTH-1:0]   rot_x;
  logic signed [ROT_SUM_WIDTH-1:0]   rot_y;
  logic signed [ROT_SHIFT_WIDTH-1:0] rot_x_sh;
  logic signed [ROT_SHIFT_WIDTH-1:0] rot_y_sh;

  logic [INDEX_WIDTH-1:0]            count_eff;
  logic [INDEX_WIDTH:0]              idx_inc;
  logic                              last;

  // Select angle zero when the request asks for a restart
  assign cur_x   = restart ? UNIT_ONE : unit_x;
  assign cur_y   = restart ? '0 : unit_y;
  assign cur_idx = restart ? '0 : vertex_index;

  // Scale by the radii, round to nearest, offset by the center
  assign prod_x   = SCALE_WIDTH'(cur_x) * SCALE_WIDTH'($signed({1'b0, cfg.radius_x}));
  assign prod_y   = SCALE_WIDTH'(cur_y) * SCALE_WIDTH'($signed({1'b0, cfg.radius_y}));
  assign rnd_x    = prod_x + SCALE_HALF;
  assign rnd_y    = prod_y + SCALE_HALF;
  assign scaled_x = rnd_x[SCALE_WIDTH-1:FRAC_BITS];
  assign scaled_y = rnd_y[SCALE_WIDTH-1:FRAC_BITS];
  assign vsum_x   = VSUM_WIDTH'(scaled_x) + VSUM_WIDTH'(cfg.center_x);
  assign vsum_y   = VSUM_WIDTH'(scaled_y) + VSUM_WIDTH'(cfg.center_y);

  // Loop position: a count of zero behaves like one
  assign count_eff = (cfg.segment_count == '0) ? INDEX_WIDTH'(1) : cfg.segment_count;
  assign idx_inc   = {1'b0, cur_idx} + (INDEX_WIDTH + 1)'(1);
  assign last      = idx_inc >= {1'b0, count_eff};

  assign vertex.vertex_x     = sat_coord(vsum_x);
  assign vertex.vertex_y     = sat_coord(vsum_y);
  assign vertex.last_of_loop = last;

  // Rotate the unit vector by the step angle
  assign p_cx     = ROT_PROD_WIDTH'(cfg.step_cosine) * ROT_PROD_WIDTH'(cur_x);
  assign p_sy     = ROT_PROD_WIDTH'(cfg.step_sine) * ROT_PROD_WIDTH'(cur_y);
  assign p_sx     = ROT_PROD_WIDTH'(cfg.step_sine) * ROT_PROD_WIDTH'(cur_x);
  assign p_cy     = ROT_PROD_WIDTH'(cfg.step_cosine) * ROT_PROD_WIDTH'(cur_y);
  assign rot_x    = ROT_SUM_WIDTH'(p_cx) - ROT_SUM_WIDTH'(p_sy) + ROT_HALF;
  assign rot_y    = ROT_SUM_WIDTH'(p_sx) + ROT_SUM_WIDTH'(p_cy) + ROT_HALF;
  assign rot_x_sh = rot_x[ROT_SUM_WIDTH-1:STEP_FRAC];
  assign rot_y_sh = rot_y[ROT_SUM_WIDTH-1:STEP_FRAC];

  // Return to angle zero after the last vertex, otherwise advance
  always_comb begin
    if (last) begin
      unit_x_next       = UNIT_ONE;
      unit_y_next       = '0;
      vertex_index_next = '0;
    end else begin
      unit_x_next       = sat_unit(rot_x_sh);
      unit_y_next       = sat_unit(rot_y_sh);
      vertex_index_next = idx_inc[INDEX_WIDTH-1:0];
    end
  end

  // Hold the rotation state between requests
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_x       <= UNIT_ONE;
      unit_y       <= '0;
      vertex_index <= '0;
    end else if (advance) begin
      unit_x       <= unit_x_next;
      unit_y       <= unit_y_next;
      vertex_index <= vertex_index_next;
    end
  end

endmodule

[sv/evr_out_buf.sv]
// ----------------------------------------------------------------------------
// evr_out_buf: two-entry output buffer
// An output register backed by a skid register, so a new request is taken
// while a finished vertex still waits downstream.
// ----------------------------------------------------------------------------
module evr_out_buf
  import evr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  vertex_t push_data,
  output logic    full,
  output logic    valid,
  input  logic    stall,
  output vertex_t data
);

  logic    skid_valid;
  vertex_t skid_data;
  logic    pop;

  assign pop  = valid && !stall;
  assign full = skid_valid;

  // Track occupancy of the output and skid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        valid <= 1'b1;
      end
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

  // Move payload: drain skid first, else load the output or park in skid
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        data <= skid_data;
      end
    end else if (push) begin
      if (valid && !pop) begin
        skid_data <= push_data;
      end else begin
        data <= push_data;
      end
    end
  end

endmodule

[sv/ellipse_rotation_vertex_generator.sv]
// ----------------------------------------------------------------------------
// ellipse_rotation_vertex_generator: ellipse outline vertex source
// Emits one vertex of an axis-aligned ellipse per request, stepping a unit
// vector around the outline by incremental rotation.
// ----------------------------------------------------------------------------
// Each request yields one vertex, and a request can be taken every cycle
// while item_stall is low: the rotation of the unit vector is a combinational
// loop (four 16x16 products, an add, round and clamp) that feeds the state
// registers directly. A two-entry output buffer lets the input keep flowing
// while one vertex waits downstream; item_stall rises only when both entries
// hold. Vertices come out in request order. A request with restart set starts
// at angle zero; the vertex flagged last_of_loop closes the outline and the
// next one starts at angle zero again. Registers may be written at any time
// with cfg_ready always high, and take effect on the next request.
// ----------------------------------------------------------------------------
module ellipse_rotation_vertex_generator
  import evr_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              restart,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]         cfg_data,
  // vertex channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [COORD_WIDTH-1:0]     vertex_x,
  output logic signed [COORD_WIDTH-1:0]     vertex_y,
  output logic                              last_of_loop
);

  cfg_t    cfg;
  vertex_t core_vertex;
  vertex_t out_vertex;
  logic    advance;
  logic    buf_full;

  assign cfg_ready  = 1'b1;
  assign item_stall = buf_full;
  assign advance    = item_valid && !buf_full;

  // Write the register selected by the request index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x      <= '0;
      cfg.center_y      <= '0;
      cfg.radius_x      <= '0;
      cfg.radius_y      <= '0;
      cfg.step_cosine   <= STEP_COS_RESET;
      cfg.step_sine     <= '0;
      cfg.segment_count <= SEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:      cfg.center_x      <= cfg_data[CENTER_WIDTH-1:0];
        REG_CENTER_Y:      cfg.center_y      <= cfg_data[CENTER_WIDTH-1:0];
        REG_RADIUS_X:      cfg.radius_x      <= cfg_data[RADIUS_WIDTH-1:0];
        REG_RADIUS_Y:      cfg.radius_y      <= cfg_data[RADIUS_WIDTH-1:0];
        REG_STEP_COSINE:   cfg.step_cosine   <= cfg_data[STEP_WIDTH-1:0];
        REG_STEP_SINE:     cfg.step_sine     <= cfg_data[STEP_WIDTH-1:0];
        REG_SEGMENT_COUNT: cfg.segment_count <= cfg_data[INDEX_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Vertex datapath and rotation state
  evr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .restart (restart),
    .cfg     (cfg),
    .vertex  (core_vertex)
  );

  // Output register with skid
  evr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (core_vertex),
    .full      (buf_full),
    .valid     (result_valid),
    .stall     (result_stall),
    .data      (out_vertex)
  );

  assign vertex_x     = out_vertex.vertex_x;
  assign vertex_y     = out_vertex.vertex_y;
  assign last_of_loop = out_vertex.last_of_loop;

endmodule
